/* design/masu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the modular add/sub unit
// no dependencies; imported by every other file of the block
package masu_pkg;

   // word geometry of operands and results
   localparam int WORD_BITS       = 64;
   localparam int IO_WORDS        = 4;
   localparam int IO_BITS         = WORD_BITS * IO_WORDS;
   localparam int FIELD_WORDS_DEF = 4;

   // modulus register geometry
   localparam int MOD_TOP_BITS  = 25;
   localparam int MOD_BITS      = 3 * WORD_BITS + MOD_TOP_BITS;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   // operation codes carried by each item
   typedef enum logic [2:0] {
      MODE_ADD     = 3'd0,
      MODE_SUB     = 3'd1,
      MODE_SUB2P   = 3'd2,
      MODE_SUB4P   = 3'd3,
      MODE_NEG     = 3'd4,
      MODE_HALVE   = 3'd5,
      MODE_CORRECT = 3'd6
   } mode_type;

   // modulus register indexes
   typedef enum logic [1:0] {
      CSR_MOD_WORD0 = 2'd0,
      CSR_MOD_WORD1 = 2'd1,
      CSR_MOD_WORD2 = 2'd2,
      CSR_MOD_WORD3 = 2'd3
   } csr_reg_type;

   // control that travels alongside the data between the two arithmetic stages
   typedef struct packed {
      mode_type mode;
      logic     borrow;
   } ctl_type;

endpackage

/* design/masu_csr.sv */
`timescale 1ns / 1ps
// modulus registers behind the apb-style configuration port
// depends on masu_pkg
module masu_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [masu_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [masu_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [masu_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic [masu_pkg::MOD_BITS-1:0]        modulus
);
   import masu_pkg::*;

   logic [WORD_BITS-1:0]    mod_word0_ff, mod_word1_ff, mod_word2_ff;
   logic [MOD_TOP_BITS-1:0] mod_word3_ff;
   csr_reg_type             reg_sel;
   logic                    wr_en;

   // registers sit on 8-byte boundaries
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_BITS-1:3]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_word0_ff <= '0;
         mod_word1_ff <= '0;
         mod_word2_ff <= '0;
         mod_word3_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            CSR_MOD_WORD0: mod_word0_ff <= pwdata;
            CSR_MOD_WORD1: mod_word1_ff <= pwdata;
            CSR_MOD_WORD2: mod_word2_ff <= pwdata;
            CSR_MOD_WORD3: mod_word3_ff <= pwdata[MOD_TOP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         CSR_MOD_WORD0: prdata = mod_word0_ff;
         CSR_MOD_WORD1: prdata = mod_word1_ff;
         CSR_MOD_WORD2: prdata = mod_word2_ff;
         CSR_MOD_WORD3: prdata = CSR_DATA_BITS'(mod_word3_ff);
         default:       prdata = '0;
      endcase
   end

   assign modulus = {mod_word3_ff, mod_word2_ff, mod_word1_ff, mod_word0_ff};

endmodule

/* design/masu_pre.sv */
`timescale 1ns / 1ps
// first arithmetic stage: the leading wide add or subtract of each operation
// depends on masu_pkg
module masu_pre #(
   parameter  int FIELD_WORDS = masu_pkg::FIELD_WORDS_DEF,
   localparam int FIELD_BITS  = masu_pkg::WORD_BITS * FIELD_WORDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid,
   input  masu_pkg::mode_type     mode,
   input  logic [FIELD_BITS-1:0]  a,
   input  logic [FIELD_BITS-1:0]  b,
   input  logic [FIELD_BITS-1:0]  p,
   input  logic [FIELD_BITS-1:0]  p2,
   output logic                   out_valid,
   output masu_pkg::ctl_type      out_ctl,
   output logic [FIELD_BITS-1:0]  out_x
);
   import masu_pkg::*;

   logic                  valid_ff;
   ctl_type               ctl_ff, ctl_in;
   logic [FIELD_BITS-1:0] x_ff, x_in;

   // leading operation, borrow kept for the fixup stage
   always_comb begin
      x_in        = '0;
      ctl_in.mode = mode;
      ctl_in.borrow = 1'b0;
      unique case (mode) inside
         MODE_ADD:                        x_in = a + b;
         MODE_SUB, MODE_SUB2P, MODE_SUB4P:
            {ctl_in.borrow, x_in} = {1'b0, a} - {1'b0, b};
         MODE_NEG:                        x_in = p2 - a;
         MODE_HALVE:                      x_in = a + (a[0] ? p : '0);
         MODE_CORRECT:
            {ctl_in.borrow, x_in} = {1'b0, a} - {1'b0, p};
         default: ;
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in;
      x_ff   <= x_in;
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;

endmodule

/* design/masu_post.sv */
`timescale 1ns / 1ps
// second arithmetic stage: conditional or fixed correction by p, 2p or 4p, and halving
// depends on masu_pkg
module masu_post #(
   parameter  int FIELD_WORDS = masu_pkg::FIELD_WORDS_DEF,
   localparam int FIELD_BITS  = masu_pkg::WORD_BITS * FIELD_WORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            valid,
   input  masu_pkg::ctl_type               ctl,
   input  logic [FIELD_BITS-1:0]           x,
   input  logic [FIELD_BITS-1:0]           p,
   input  logic [FIELD_BITS-1:0]           p2,
   input  logic [FIELD_BITS-1:0]           p4,
   output logic                            out_valid,
   output logic [masu_pkg::IO_BITS-1:0]    out_result
);
   import masu_pkg::*;

   logic                  valid_ff;
   logic [IO_BITS-1:0]    result_ff;
   logic [FIELD_BITS-1:0] addend, sum, res_in;
   logic                  do_sub, sum_borrow;

   // pick the correction term and its direction
   always_comb begin
      addend = '0;
      do_sub = 1'b0;
      unique case (ctl.mode) inside
         MODE_ADD: begin
            addend = p2;
            do_sub = 1'b1;
         end
         MODE_SUB, MODE_SUB2P: addend = p2;
         MODE_SUB4P:           addend = p4;
         MODE_CORRECT:         addend = p;
         default: ;
      endcase
   end

   // single shared adder
   always_comb begin
      if (do_sub) begin
         {sum_borrow, sum} = {1'b0, x} - {1'b0, addend};
      end else begin
         {sum_borrow, sum} = {1'b0, x} + {1'b0, addend};
      end
   end

   // result select
   always_comb begin
      unique case (ctl.mode) inside
         MODE_ADD:               res_in = sum_borrow ? x : sum;
         MODE_SUB, MODE_CORRECT: res_in = ctl.borrow ? sum : x;
         MODE_SUB2P, MODE_SUB4P: res_in = sum;
         MODE_NEG:               res_in = x;
         MODE_HALVE:             res_in = x >> 1;
         default:                res_in = '0;
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   // result register, low words only
   always_ff @(posedge clock) begin
      result_ff <= res_in[IO_BITS-1:0];
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* design/modular_add_sub_unit_core.sv */
`timescale 1ns / 1ps
// top level of the modular add/sub unit: input register, two arithmetic stages, csr block
// depends on masu_pkg, masu_csr, masu_pre, masu_post
//
// Usage:
//   An item (mode, operands a and b) is taken at a rising edge with start high and busy
//   low. busy is never raised: the pipeline takes one item every cycle.
//   Each item gives one result on rsp_result_word0..3, shown for exactly one cycle with
//   rsp_valid high. An item passes the input register, then the registers of the two arithmetic
//   stages, before its result is on the ports; throughput is 1 item per cycle; results leave
//   in the order items came in. The depth is set by the input register and the two wide
//   add/subtract stages, each holding one 64*FIELD_WORDS-bit adder.
//   The receiver cannot stall; it must take each result in the cycle it is shown.
//   The modulus p must be written through the apb-style port (64-bit registers at byte
//   addresses 0, 8, 16, 24) while no item is in flight; the block itself does not enforce it.
//   2p and 4p follow from p. Synchronous reset clears the valid bits of every stage and the
//   modulus to zero; items in flight at reset are dropped. Mode 7 gives an all-zero result.
module modular_add_sub_unit_core #(
   parameter int FIELD_WORDS = masu_pkg::FIELD_WORDS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // item input
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_mode,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_a_word0,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_a_word1,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_a_word2,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_a_word3,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_b_word0,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_b_word1,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_b_word2,
   input  logic [masu_pkg::WORD_BITS-1:0]       req_b_word3,
   // result output
   output logic                                 rsp_valid,
   output logic [masu_pkg::WORD_BITS-1:0]       rsp_result_word0,
   output logic [masu_pkg::WORD_BITS-1:0]       rsp_result_word1,
   output logic [masu_pkg::WORD_BITS-1:0]       rsp_result_word2,
   output logic [masu_pkg::WORD_BITS-1:0]       rsp_result_word3,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [masu_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [masu_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [masu_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import masu_pkg::*;

   localparam int FIELD_BITS = WORD_BITS * FIELD_WORDS;

   logic                  in_valid_ff;
   mode_type              in_mode_ff;
   logic [IO_BITS-1:0]    in_a_ff, in_b_ff;
   logic [MOD_BITS-1:0]   modulus;
   logic [FIELD_BITS-1:0] p, p2, p4, a_ext, b_ext, pre_x;
   logic                  pre_valid;
   ctl_type               pre_ctl;
   logic [IO_BITS-1:0]    result;

   assign busy = 1'b0;

   // modulus registers
   masu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .modulus (modulus)
   );

   // derived multiples of p, bits past the top dropped
   assign p  = FIELD_BITS'(modulus);
   assign p2 = p << 1;
   assign p4 = p << 2;

   // input register valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      in_mode_ff <= mode_type'(req_mode);
      in_a_ff    <= {req_a_word3, req_a_word2, req_a_word1, req_a_word0};
      in_b_ff    <= {req_b_word3, req_b_word2, req_b_word1, req_b_word0};
   end

   assign a_ext = FIELD_BITS'(in_a_ff);
   assign b_ext = FIELD_BITS'(in_b_ff);

   // leading add/subtract
   masu_pre #(
      .FIELD_WORDS (FIELD_WORDS)
   ) u_pre (
      .clock     (clock),
      .reset     (reset),
      .valid     (in_valid_ff),
      .mode      (in_mode_ff),
      .a         (a_ext),
      .b         (b_ext),
      .p         (p),
      .p2        (p2),
      .out_valid (pre_valid),
      .out_ctl   (pre_ctl),
      .out_x     (pre_x)
   );

   // correction and halving
   masu_post #(
      .FIELD_WORDS (FIELD_WORDS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .valid      (pre_valid),
      .ctl        (pre_ctl),
      .x          (pre_x),
      .p          (p),
      .p2         (p2),
      .p4         (p4),
      .out_valid  (rsp_valid),
      .out_result (result)
   );

   assign rsp_result_word0 = result[WORD_BITS-1:0];
   assign rsp_result_word1 = result[2*WORD_BITS-1:WORD_BITS];
   assign rsp_result_word2 = result[3*WORD_BITS-1:2*WORD_BITS];
   assign rsp_result_word3 = result[4*WORD_BITS-1:3*WORD_BITS];

   // every accepted item shows up as a result strobe after the input and both stage registers, none invented
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3))
         |-> (rsp_valid == $past(start, 3)))
      else $error("result strobe does not follow accepted item by three cycles");

   // the output stage only fires on what the first arithmetic stage held
   a_stage_chain: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && rsp_valid) |-> $past(pre_valid))
      else $error("result strobe without an item in the first arithmetic stage");

   // the middle stage only fires on what the input register held
   a_input_chain: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset, 1) && pre_valid) |-> $past(in_valid_ff))
      else $error("first arithmetic stage valid without a registered item");

endmodule

/* tb/modular_add_sub_unit_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the modular add/sub unit: register access, directed and random items
// depends on masu_pkg and the design files of modular_add_sub_unit_core
module modular_add_sub_unit_core_tb;
   import masu_pkg::*;

   localparam int CLK_HALF           = 10;
   localparam int RESET_CYCLES       = 12;
   localparam int PIPE_LATENCY       = 3;
   localparam int MAX_SHOWN          = 10;
   localparam int RANDOM_PER_SETTING = 122;
   localparam int NUM_SETTINGS       = 6;
   localparam int TIMEOUT_NS         = 4000000;

   // mode code with no operation behind it
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef logic [IO_BITS-1:0] field_type;

   localparam field_type   ALL_ONES = '1;
   localparam logic [63:0] TOP_MASK = (64'd1 << MOD_TOP_BITS) - 64'd1;

   typedef struct {
      logic [2:0] mode;
      field_type  value;
   } field_result_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // item channel
   logic                 start = 1'b0;
   logic                 busy;
   logic [2:0]           req_mode = '0;
   logic [WORD_BITS-1:0] req_a_word0 = '0, req_a_word1 = '0, req_a_word2 = '0, req_a_word3 = '0;
   logic [WORD_BITS-1:0] req_b_word0 = '0, req_b_word1 = '0, req_b_word2 = '0, req_b_word3 = '0;

   // result channel
   logic                 rsp_valid;
   logic [WORD_BITS-1:0] rsp_result_word0, rsp_result_word1, rsp_result_word2, rsp_result_word3;

   // register port
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // modulus copy, expected results and run statistics
   logic [63:0]      mod_shadow [IO_WORDS];
   field_result_type expected_results [$];
   int               send_idle_pct = 0;
   int               error_count = 0;
   int               items_sent = 0;
   int               results_checked = 0;
   int               settings_used = 0;

   modular_add_sub_unit_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_a_word0      (req_a_word0),
      .req_a_word1      (req_a_word1),
      .req_a_word2      (req_a_word2),
      .req_a_word3      (req_a_word3),
      .req_b_word0      (req_b_word0),
      .req_b_word1      (req_b_word1),
      .req_b_word2      (req_b_word2),
      .req_b_word3      (req_b_word3),
      .rsp_valid        (rsp_valid),
      .rsp_result_word0 (rsp_result_word0),
      .rsp_result_word1 (rsp_result_word1),
      .rsp_result_word2 (rsp_result_word2),
      .rsp_result_word3 (rsp_result_word3),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // free-running clock
   always #(CLK_HALF) clock = ~clock;

   initial begin
      for (int i = 0; i < IO_WORDS; i++) mod_shadow[i] = '0;
   end

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= MAX_SHOWN) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic field_type modulus_value();
      return {mod_shadow[3], mod_shadow[2], mod_shadow[1], mod_shadow[0]};
   endfunction

   // lazy-reduction field arithmetic, everything wraps at 256 bits
   function automatic field_type predict_field_op(logic [2:0] mode, field_type a, field_type b);
      field_type p, p2, p4, t;
      p  = modulus_value();
      p2 = p << 1;
      p4 = p << 2;
      case (mode)
         MODE_ADD: begin
            t = a + b;
            if (t >= p2) t = t - p2;
         end
         MODE_SUB: begin
            t = a - b;
            if (a < b) t = t + p2;
         end
         MODE_SUB2P:   t = a - b + p2;
         MODE_SUB4P:   t = a - b + p4;
         MODE_NEG:     t = p2 - a;
         MODE_HALVE: begin
            t = a[0] ? a + p : a;
            t = t >> 1;
         end
         MODE_CORRECT: t = (a < p) ? a : a - p;
         default:      t = '0;
      endcase
      return t;
   endfunction

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      field_result_type head;
      field_type        got;
      if (!reset && rsp_valid) begin
         got = {rsp_result_word3, rsp_result_word2, rsp_result_word1, rsp_result_word0};
         if (expected_results.size() == 0) begin
            note_error($sformatf("result with nothing expected: %h", got));
         end else begin
            head = expected_results.pop_front();
            results_checked++;
            for (int w = 0; w < IO_WORDS; w++) begin
               if (got[w*64 +: 64] !== head.value[w*64 +: 64]) begin
                  note_error($sformatf("mode %0d result_word%0d expected %h got %h",
                                       head.mode, w, head.value[w*64 +: 64], got[w*64 +: 64]));
               end
            end
         end
      end
   end

   // send one item, with random idle cycles ahead of it
   task automatic send_item(logic [2:0] mode, field_type a, field_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_mode    <= mode;
      req_a_word0 <= a[63:0];
      req_a_word1 <= a[127:64];
      req_a_word2 <= a[191:128];
      req_a_word3 <= a[255:192];
      req_b_word0 <= b[63:0];
      req_b_word1 <= b[127:64];
      req_b_word2 <= b[191:128];
      req_b_word3 <= b[255:192];
      do @(posedge clock); while (busy);
      expected_results.push_back('{mode, predict_field_op(mode, a, b)});
      items_sent++;
   endtask

   task automatic stop_items();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // wait for the pipeline to empty
   task automatic wait_idle();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      mod_shadow[idx] = (idx == CSR_MOD_WORD3) ? (value & TOP_MASK) : value;
      @(posedge clock);
   endtask

   task automatic csr_read_check(csr_reg_type idx);
      logic [63:0] data;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (data !== mod_shadow[idx])
         note_error($sformatf("readback of modulus_word%0d expected %h got %h",
                              idx, mod_shadow[idx], data));
      @(posedge clock);
   endtask

   // write all four modulus words, junk above the top field, then read them back
   task automatic load_modulus(field_type pv);
      logic [63:0] word;
      wait_idle();
      for (int i = 0; i < IO_WORDS; i++) begin
         word = pv[i*64 +: 64];
         if (i == CSR_MOD_WORD3) word = ({$urandom, $urandom} & ~TOP_MASK) | (word & TOP_MASK);
         csr_write(csr_reg_type'(i), word);
      end
      for (int i = 0; i < IO_WORDS; i++) csr_read_check(csr_reg_type'(i));
      settings_used++;
   endtask

   function automatic field_type rand_field();
      field_type v;
      for (int i = 0; i < IO_BITS / 32; i++) v[i*32 +: 32] = $urandom;
      return v;
   endfunction

   // random odd modulus of the given width with its top bit set
   function automatic field_type rand_modulus(int bits);
      field_type v;
      v = rand_field() & ((field_type'(1) << bits) - 1);
      v[bits-1] = 1'b1;
      v[0] = 1'b1;
      return v;
   endfunction

   function automatic field_type corner_value();
      field_type p;
      p = modulus_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return p;
         3:       return p - 1;
         4:       return (p << 1) - 1;
         5:       return p << 1;
         6:       return (p << 2) - 1;
         default: return field_type'(1);
      endcase
   endfunction

   // mostly lazily reduced operands, some full-width noise and corners
   function automatic field_type pick_operand(field_type bound);
      int r;
      r = $urandom_range(99);
      if (r < 75) return (bound == 0) ? rand_field() : rand_field() % bound;
      if (r < 90) return rand_field();
      return corner_value();
   endfunction

   // every mode with the modulus still at its reset value
   task automatic test_unconfigured_modulus();
      for (int m = 0; m < 8; m++) send_item(m[2:0], rand_field(), rand_field());
      stop_items();
   endtask

   // register writes and readback at both extremes of the modulus
   task automatic test_register_access();
      load_modulus('0);
      load_modulus((field_type'(1) << MOD_BITS) - 1);
   endtask

   // edges of each operation around a typical modulus
   task automatic test_directed_cases();
      field_type p, p2;
      load_modulus(rand_modulus(MOD_BITS));
      p  = modulus_value();
      p2 = p << 1;
      send_item(MODE_ADD, '0, '0);
      send_item(MODE_ADD, p2 - 1, p2 - 1);
      send_item(MODE_ADD, p, p);
      send_item(MODE_ADD, ALL_ONES, ALL_ONES);
      send_item(MODE_SUB, '0, p2 - 1);
      send_item(MODE_SUB, p - 1, p - 1);
      send_item(MODE_SUB2P, '0, p2 - 1);
      send_item(MODE_SUB4P, '0, ALL_ONES);
      send_item(MODE_NEG, '0, rand_field());
      send_item(MODE_NEG, p2, rand_field());
      send_item(MODE_HALVE, p - 1, rand_field());
      send_item(MODE_HALVE, p2 - 1, rand_field());
      send_item(MODE_HALVE, ALL_ONES, rand_field());
      send_item(MODE_CORRECT, p - 1, rand_field());
      send_item(MODE_CORRECT, p, rand_field());
      send_item(MODE_CORRECT, p2 - 1, rand_field());
      send_item(MODE_CORRECT, ALL_ONES, rand_field());
      send_item(MODE_UNUSED, ALL_ONES, ALL_ONES);
      stop_items();
   endtask

   // random items over several moduli and idle profiles
   task automatic test_random_stream();
      field_type  moduli [NUM_SETTINGS];
      field_type  p;
      logic [2:0] mode;
      moduli[0] = rand_modulus(MOD_BITS);
      moduli[1] = (field_type'(1) << MOD_BITS) - 1;
      moduli[2] = field_type'(3);
      moduli[3] = rand_modulus(MOD_BITS);
      moduli[4] = '0;
      moduli[5] = rand_modulus(64 + $urandom_range(100));
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         send_idle_pct = (s < 2) ? 29 : (s < 4) ? 45 : 0;
         load_modulus(moduli[s]);
         p = modulus_value();
         for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
            mode = ($urandom_range(99) < 3) ? MODE_UNUSED : 3'($urandom_range(6));
            send_item(mode, pick_operand(p << 1),
                      pick_operand((mode == MODE_SUB4P) ? (p << 2) : (p << 1)));
         end
         stop_items();
      end
   endtask

   // test sequence
   initial begin
      send_idle_pct = 29;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unconfigured_modulus();
      test_register_access();
      test_directed_cases();
      test_random_stream();
      wait_idle();
      if (expected_results.size() != 0)
         note_error($sformatf("%0d results never arrived", expected_results.size()));
      $display("summary: %0d items sent, %0d results checked, %0d modulus settings",
               items_sent, results_checked, settings_used);
      $display("covered all mode codes, zero and full-width moduli, idle and back-to-back traffic");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
